// ===== src/imf_pkg.sv =====
// Shared types and constants for the mixed integer / float ALU.
// Used by every module of the block; depends on nothing.
package imf_pkg;

   localparam int DATA_W = 32;
   localparam int DIV_STEPS = DATA_W;

   typedef enum logic [3:0] {
      OP_ADD    = 4'd0,
      OP_SUB    = 4'd1,
      OP_MUL    = 4'd2,
      OP_DIV    = 4'd3,
      OP_LT     = 4'd4,
      OP_GT     = 4'd5,
      OP_EQ     = 4'd6,
      OP_LE     = 4'd7,
      OP_GE     = 4'd8,
      OP_ASSIGN = 4'd9
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_CONV   = 2'd1,
      ST_DIV0   = 2'd2,
      ST_DIVOVF = 2'd3
   } status_type;

   // Word in flight through the divider stages. Non-divide ops ride along
   // with their final result already settled.
   typedef struct packed {
      logic               div;
      logic               neg;
      logic [DATA_W-1:0]  rem;
      logic [DATA_W-1:0]  num;
      logic [DATA_W-1:0]  den;
      logic [DATA_W-1:0]  res;
      logic               flag;
      status_type         st;
   } stage_type;

endpackage

// ===== src/imf_f2i.sv =====
// Truncating single-precision to 32-bit integer conversion with saturation.
// Depends on imf_pkg.
module imf_f2i import imf_pkg::*; (
   input  logic [DATA_W-1:0] float_bits,
   output logic [DATA_W-1:0] int_value,
   output logic              sat
);
   logic       sign;
   logic [7:0] expo;
   logic [22:0] mant;
   logic [DATA_W-1:0] mag;

   assign sign = float_bits[31];
   assign expo = float_bits[30:23];
   assign mant = float_bits[22:0];

   always_comb begin
      mag = {8'd0, 1'b1, mant};
      if (expo >= 8'd150) begin
         mag = mag << 3'(expo - 8'd150);
      end else begin
         mag = mag >> 5'(8'd150 - expo);
      end
      sat = 1'b0;
      int_value = sign ? (~mag + 32'd1) : mag;
      if (expo == 8'hFF) begin
         sat = 1'b1;
         if (mant != 23'd0) begin
            int_value = '0;
         end else begin
            int_value = sign ? 32'h8000_0000 : 32'h7FFF_FFFF;
         end
      end else if (expo < 8'd127) begin
         int_value = '0;
      end else if (expo >= 8'd158) begin
         int_value = sign ? 32'h8000_0000 : 32'h7FFF_FFFF;
         sat = !(sign && expo == 8'd158 && mant == 23'd0);
      end
   end
endmodule

// ===== src/imf_div_step.sv =====
// One restoring step of the unsigned divider: one quotient bit per stage.
// Depends on imf_pkg.
module imf_div_step import imf_pkg::*; (
   input  stage_type d_in,
   output stage_type d_out
);
   logic [DATA_W:0] trial;
   logic [DATA_W:0] diff;

   always_comb begin
      d_out = d_in;
      trial = {d_in.rem, d_in.num[DATA_W-1]};
      diff  = trial - {1'b0, d_in.den};
      if (d_in.div) begin
         if (!diff[DATA_W]) begin
            d_out.rem = diff[DATA_W-1:0];
         end else begin
            d_out.rem = trial[DATA_W-1:0];
         end
         d_out.num = {d_in.num[DATA_W-2:0], !diff[DATA_W]};
      end
   end
endmodule

// ===== src/int_float_mixed_alu.sv =====
// Top level of the mixed integer / float ALU: conversion, ALU and divider pipeline.
// Depends on imf_pkg, imf_f2i and imf_div_step.
//
//  channel | dir | tdata                                      | tuser
//  req     | in  | [31:0] int_operand, [63:32] float_bits     | [3:0] opcode
//  rsp     | out | [31:0] int_result, [32] compare_flag,      | -
//          |     | [34:33] status                             |
//
// One word enters per cycle unless the output stalls. Stages: convert, ALU,
// 32 divider steps, sign fix. The 32 one-bit divider stages set the latency.
// Reset clears all valid bits. A stalled output holds the whole pipeline.
module int_float_mixed_alu import imf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // int_operand, float_bits
   input  logic [3:0]  req_tuser,   // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // int_result, compare_flag, status, zero pad
);
   logic advance;

   logic              s1_valid_ff;
   logic [3:0]        s1_op_ff;
   logic [DATA_W-1:0] s1_a_ff;
   logic [DATA_W-1:0] s1_b_ff;
   logic              s1_sat_ff;
   logic [DATA_W-1:0] conv_in;
   logic              sat_in;

   logic      s2_valid_ff;
   stage_type s2_ff;
   stage_type s2_in;

   logic      dv_valid_ff [DIV_STEPS];
   stage_type dv_ff [DIV_STEPS];
   stage_type dv_in [DIV_STEPS];

   logic              out_valid_ff;
   logic [DATA_W-1:0] out_res_ff;
   logic              out_flag_ff;
   status_type        out_st_ff;
   logic [DATA_W-1:0] out_res_in;

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = advance;

   imf_f2i u_f2i (
      .float_bits (req_tdata[63:32]),
      .int_value  (conv_in),
      .sat        (sat_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_tvalid;
      end
      if (advance) begin
         s1_op_ff  <= req_tuser;
         s1_a_ff   <= req_tdata[31:0];
         s1_b_ff   <= conv_in;
         s1_sat_ff <= sat_in;
      end
   end

   always_comb begin
      logic a_neg;
      logic b_neg;
      a_neg = s1_a_ff[DATA_W-1];
      b_neg = s1_b_ff[DATA_W-1];
      s2_in      = '0;
      s2_in.st   = s1_sat_ff ? ST_CONV : ST_OK;
      s2_in.num  = a_neg ? (~s1_a_ff + 32'd1) : s1_a_ff;
      s2_in.den  = b_neg ? (~s1_b_ff + 32'd1) : s1_b_ff;
      s2_in.neg  = a_neg ^ b_neg;
      case (s1_op_ff)
         OP_ADD:    s2_in.res = s1_a_ff + s1_b_ff;
         OP_SUB:    s2_in.res = s1_a_ff - s1_b_ff;
         OP_MUL:    s2_in.res = s1_a_ff * s1_b_ff;
         OP_DIV: begin
            if (s1_b_ff == '0) begin
               s2_in.st = ST_DIV0;
            end else if (s1_a_ff == 32'h8000_0000 && s1_b_ff == 32'hFFFF_FFFF) begin
               s2_in.res = 32'h8000_0000;
               s2_in.st  = ST_DIVOVF;
            end else begin
               s2_in.div = 1'b1;
            end
         end
         OP_LT:     s2_in.flag = $signed(s1_a_ff) <  $signed(s1_b_ff);
         OP_GT:     s2_in.flag = $signed(s1_a_ff) >  $signed(s1_b_ff);
         OP_EQ:     s2_in.flag = s1_a_ff == s1_b_ff;
         OP_LE:     s2_in.flag = $signed(s1_a_ff) <= $signed(s1_b_ff);
         OP_GE:     s2_in.flag = $signed(s1_a_ff) >= $signed(s1_b_ff);
         OP_ASSIGN: s2_in.res = s1_b_ff;
         default:   s2_in.st = ST_OK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (advance) begin
         s2_ff <= s2_in;
      end
   end

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
      if (i == 0) begin : g_first
         imf_div_step u_step (.d_in(s2_ff), .d_out(dv_in[i]));
      end else begin : g_next
         imf_div_step u_step (.d_in(dv_ff[i-1]), .d_out(dv_in[i]));
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[i] <= 1'b0;
         end else if (advance) begin
            dv_valid_ff[i] <= (i == 0) ? s2_valid_ff : dv_valid_ff[(i == 0) ? 0 : i-1];
         end
         if (advance) begin
            dv_ff[i] <= dv_in[i];
         end
      end
   end

   always_comb begin
      out_res_in = dv_ff[DIV_STEPS-1].res;
      if (dv_ff[DIV_STEPS-1].div) begin
         out_res_in = dv_ff[DIV_STEPS-1].neg ? (~dv_ff[DIV_STEPS-1].num + 32'd1)
                                             : dv_ff[DIV_STEPS-1].num;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= dv_valid_ff[DIV_STEPS-1];
      end
      if (advance) begin
         out_res_ff  <= out_res_in;
         out_flag_ff <= dv_ff[DIV_STEPS-1].flag;
         out_st_ff   <= dv_ff[DIV_STEPS-1].st;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, out_st_ff, out_flag_ff, out_res_ff};
endmodule

// ===== src/imf_checker.sv =====
// Port-level checks for the mixed integer / float ALU, bound to the top level.
// Depends on imf_pkg and int_float_mixed_alu.
module imf_checker import imf_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[32] |-> rsp_tdata[31:0] == 32'd0)
      else $error("compare result with nonzero value");

   a_div0: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[34:33] == ST_DIV0 |-> rsp_tdata[32:0] == 33'd0)
      else $error("divide by zero with nonzero result");

   a_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[34:33] == ST_DIVOVF |-> rsp_tdata[31:0] == 32'h8000_0000)
      else $error("division overflow with wrong result");
endmodule

bind int_float_mixed_alu imf_checker u_imf_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
